/* rtl/qme_pkg.sv */
package qme_pkg;

   localparam int QueueDepthDefault = 1024;
   localparam int NumRegs = 26;
   localparam int WordWidth = 16;

   typedef enum logic [3:0] {
      KIND_PUSH_IMM = 4'd0,
      KIND_ADD = 4'd1,
      KIND_SUB = 4'd2,
      KIND_MUL = 4'd3,
      KIND_DIV = 4'd4,
      KIND_MOD = 4'd5,
      KIND_POP_REG = 4'd6,
      KIND_PUSH_REG = 4'd7,
      KIND_PRINT_NUM = 4'd8,
      KIND_PRINT_CHAR = 4'd9,
      KIND_JUMP = 4'd10,
      KIND_JZ = 4'd11,
      KIND_JE = 4'd12,
      KIND_JG = 4'd13,
      KIND_QUIT = 4'd14,
      KIND_NOP = 4'd15
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the item
      logic pop_start;  // issue memory read at head
      logic pop_x;      // take read data as x
      logic pop_y;      // take read data as y
      logic div_start;
      logic finish;     // commit push/register write and form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic from_reg;   // captured print source
   } status_type;

endpackage

/* rtl/qme_divider.sv */
module qme_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [qme_pkg::WordWidth-1:0] dividend,
   input  logic [qme_pkg::WordWidth-1:0] divisor,
   output logic done,
   output logic [qme_pkg::WordWidth-1:0] quotient,
   output logic [qme_pkg::WordWidth-1:0] remainder
);
   import qme_pkg::*;

   localparam int CntW = $clog2(WordWidth + 1);

   logic [WordWidth-1:0] quo_ff, quo_in, den_ff, den_in;
   logic [WordWidth:0] rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [WordWidth:0] trial;

   always_comb begin
      trial = {rem_ff[WordWidth-1:0], quo_ff[WordWidth-1]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CntW'(WordWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[WordWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[WordWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff[WordWidth-1:0];
endmodule

/* rtl/qme_datapath.sv */
module qme_datapath #(
   parameter int QUEUE_DEPTH = qme_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  qme_pkg::cmd_type cmd,
   output qme_pkg::status_type status,
   input  logic [3:0] req_kind,
   input  logic [4:0] req_reg_first,
   input  logic [4:0] req_reg_second,
   input  logic req_from_register,
   input  logic [15:0] req_immediate,
   output logic [3:0] kind,
   output logic rsp_branch_taken,
   output logic rsp_halted,
   output logic rsp_print_valid,
   output logic rsp_print_is_char,
   output logic [15:0] rsp_print_value,
   output logic rsp_queue_error
);
   import qme_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WordWidth-1:0] mem [QUEUE_DEPTH];
   logic [WordWidth-1:0] rd_ff;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [WordWidth-1:0] regs_ff [NumRegs];
   logic [3:0] kind_ff;
   logic [4:0] ra_ff, rb_ff;
   logic from_ff;
   logic [WordWidth-1:0] imm_ff, x_ff, x_in, y_ff, y_in;
   logic err_ff, err_in;
   logic pop_ok_ff;
   logic [WordWidth-1:0] ra_val, rb_val, push_val, quo, rem, pval;
   logic push_en, do_push, reg_wr, push_err, pop_now, is_print, taken;
   logic [2*WordWidth-1:0] prod;
   logic div_done;
   logic tk_ff, hl_ff, pv_ff, pc_ff, qe_ff;
   logic [WordWidth-1:0] pvv_ff;

   qme_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(x_ff), .divisor(y_ff), .done(div_done),
      .quotient(quo), .remainder(rem)
   );
   assign status = {div_done, from_ff};

   assign ra_val = (ra_ff < 5'(NumRegs)) ? regs_ff[ra_ff] : '0;
   assign rb_val = (rb_ff < 5'(NumRegs)) ? regs_ff[rb_ff] : '0;
   assign prod = x_ff * y_ff;
   assign pop_now = cmd.pop_start && (count_ff != '0);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      err_in = err_ff;
      if (cmd.load) err_in = 1'b0;
      if (cmd.pop_start && count_ff == '0) err_in = 1'b1;
      if (cmd.pop_x) x_in = pop_ok_ff ? rd_ff : '0;
      if (cmd.pop_y) y_in = pop_ok_ff ? rd_ff : '0;
      head_in = head_ff;
      if (pop_now) head_in = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      push_en = 1'b0;
      push_val = '0;
      reg_wr = 1'b0;
      is_print = 1'b0;
      taken = 1'b0;
      pval = '0;
      case (kind_type'(kind_ff))
         KIND_PUSH_IMM: begin push_en = 1'b1; push_val = imm_ff; end
         KIND_ADD: begin push_en = 1'b1; push_val = x_ff + y_ff; end
         KIND_SUB: begin push_en = 1'b1; push_val = x_ff - y_ff; end
         KIND_MUL: begin push_en = 1'b1; push_val = prod[WordWidth-1:0]; end
         KIND_DIV: begin push_en = 1'b1; push_val = (y_ff == '0) ? '0 : quo; end
         KIND_MOD: begin push_en = 1'b1; push_val = (y_ff == '0) ? '0 : rem; end
         KIND_POP_REG: reg_wr = 1'b1;
         KIND_PUSH_REG: begin push_en = 1'b1; push_val = ra_val; end
         KIND_PRINT_NUM, KIND_PRINT_CHAR: begin
            is_print = 1'b1;
            pval = from_ff ? ra_val : x_ff;
         end
         KIND_JUMP: taken = 1'b1;
         KIND_JZ: taken = (ra_val == '0);
         KIND_JE: taken = (ra_val == rb_val);
         KIND_JG: taken = (ra_val > rb_val);
         default: ;
      endcase
      do_push = cmd.finish && push_en && (count_ff != CW'(QUEUE_DEPTH));
      push_err = cmd.finish && push_en && (count_ff == CW'(QUEUE_DEPTH));
      tail_in = tail_ff;
      if (do_push) tail_in = (tail_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      count_in = count_ff;
      if (pop_now) count_in = count_ff - 1'b1;
      else if (do_push) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         if (cmd.finish && reg_wr && ra_ff < 5'(NumRegs)) regs_ff[ra_ff] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[tail_ff] <= push_val;
      rd_ff <= mem[head_ff];
      pop_ok_ff <= pop_now;
      if (cmd.load) begin
         kind_ff <= req_kind;
         ra_ff <= req_reg_first;
         rb_ff <= req_reg_second;
         from_ff <= req_from_register;
         imm_ff <= req_immediate;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      err_ff <= err_in;
      if (cmd.finish) begin
         tk_ff <= taken;
         hl_ff <= (kind_type'(kind_ff) == KIND_QUIT);
         pv_ff <= is_print;
         pc_ff <= (kind_type'(kind_ff) == KIND_PRINT_CHAR);
         pvv_ff <= pval;
         qe_ff <= err_ff | push_err;
      end
   end

   assign kind = kind_ff;
   assign rsp_branch_taken = tk_ff;
   assign rsp_halted = hl_ff;
   assign rsp_print_valid = pv_ff;
   assign rsp_print_is_char = pc_ff;
   assign rsp_print_value = pvv_ff;
   assign rsp_queue_error = qe_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH)) else $error("count beyond depth");
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(pop_now && do_push)) else $error("pop and push together");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff)) else $error("pointers apart when empty");
`endif
endmodule

/* rtl/qme_controller.sv */
module qme_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  logic [3:0] kind,
   input  qme_pkg::status_type status,
   output qme_pkg::cmd_type cmd
);
   import qme_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_POPX, S_WAITX, S_POPY, S_WAITY, S_DIV, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic out_ff, out_in;
   logic div_go_ff, div_go_in;
   logic needs_x, needs_y, accept;

   always_comb begin
      needs_y = (kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD});
      needs_x = needs_y || kind == KIND_POP_REG ||
                ((kind == KIND_PRINT_NUM || kind == KIND_PRINT_CHAR) && !status.from_reg);
   end

   assign req_stall = (state_ff != S_IDLE) || (out_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && rsp_stall;
      div_go_in = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (accept) begin
            cmd.load = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: state_in = needs_x ? S_POPX : S_FINISH;
         S_POPX: begin cmd.pop_start = 1'b1; state_in = S_WAITX; end
         S_WAITX: begin
            cmd.pop_x = 1'b1;
            state_in = needs_y ? S_POPY : S_FINISH;
         end
         S_POPY: begin cmd.pop_start = 1'b1; state_in = S_WAITY; end
         S_WAITY: begin
            cmd.pop_y = 1'b1;
            if (kind == KIND_DIV || kind == KIND_MOD) begin
               state_in = S_DIV;
               div_go_in = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (status.div_done) state_in = S_FINISH;
         end
         S_FINISH: if (!(out_ff && rsp_stall)) begin
            cmd.finish = 1'b1;
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // divider starts the cycle after y is captured
      cmd.div_start = div_go_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
         div_go_ff <= div_go_in;
      end
   end

`ifndef SYNTH
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.finish && cmd.pop_start)) else $error("finish during pop");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_DECODE)) else $error("load without decode");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result lost");
`endif
endmodule

/* rtl/queue_machine_executor_core.sv */
// channel | valid     | stall     | payload
// req     | req_valid | req_stall | req_kind req_reg_first req_reg_second
//         |           |           | req_from_register req_immediate
// rsp     | rsp_valid | rsp_stall | rsp_branch_taken rsp_halted rsp_print_valid
//         |           |           | rsp_print_is_char rsp_print_value rsp_queue_error
// one item at a time: decode, then up to two queue pops, then the divider for
// divide and modulo (16-step shift-subtract divider), then finish
// queue reads use one registered memory port; a pop reads, then takes the data
// synchronous reset clears pointers, count and registers; queue memory is not cleared
// a stalled result holds; the next item waits until the result register frees
module queue_machine_executor_core #(
   parameter int QUEUE_DEPTH = qme_pkg::QueueDepthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [3:0] req_kind,
   input  logic [4:0] req_reg_first,
   input  logic [4:0] req_reg_second,
   input  logic req_from_register,
   input  logic [15:0] req_immediate,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_branch_taken,
   output logic rsp_halted,
   output logic rsp_print_valid,
   output logic rsp_print_is_char,
   output logic [15:0] rsp_print_value,
   output logic rsp_queue_error
);
   import qme_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [3:0] kind;

   qme_controller u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind),
      .status(status), .cmd(cmd)
   );

   qme_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_kind(req_kind), .req_reg_first(req_reg_first),
      .req_reg_second(req_reg_second), .req_from_register(req_from_register),
      .req_immediate(req_immediate), .kind(kind),
      .rsp_branch_taken(rsp_branch_taken), .rsp_halted(rsp_halted),
      .rsp_print_valid(rsp_print_valid), .rsp_print_is_char(rsp_print_is_char),
      .rsp_print_value(rsp_print_value), .rsp_queue_error(rsp_queue_error)
   );
endmodule
